FILE: sv/rgb_window_convolution_defines.svh
// Assertion macros used by the checker file of the RGB window convolution.
// No dependencies.
`ifndef RGB_WINDOW_CONVOLUTION_DEFINES_SVH
`define RGB_WINDOW_CONVOLUTION_DEFINES_SVH

// check an implication outside of reset
`define RWC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rwc check failed");

// check an implication that includes the reset cycle
`define RWC_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rwc reset check failed");

`endif

FILE: sv/rwc_pkg.sv
// Shared constants and types of the RGB window convolution.
// No dependencies.
`default_nettype none

package rwc_pkg;

    localparam int KERNEL_SIZE_DEF = 10;
    localparam int MAX_WIDTH_DEF   = 4096;

    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int ROW_W      = 12;
    localparam int HGT_W      = 13;
    localparam int MAX_HEIGHT = 4096;
    localparam int COEF_W     = 16;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int PROD_W     = COEF_W + CH_W;
    localparam int FRAC_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef struct packed {
        logic            frame_end;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_result;

    typedef struct packed {
        logic valid;
        logic frame_end;
    } t_tag;

endpackage

`default_nettype wire

FILE: sv/rwc_mac.sv
// Multiply-accumulate pipeline over the window for all three channels.
// Depends on rwc_pkg.
`default_nettype none

module rwc_mac #(
    parameter int KERNEL_SIZE = rwc_pkg::KERNEL_SIZE_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire rwc_pkg::t_tag         i_tag,
    input  wire [rwc_pkg::PIX_W-1:0]   i_window [KERNEL_SIZE*KERNEL_SIZE],
    input  wire [rwc_pkg::COEF_W-1:0]  i_coef   [KERNEL_SIZE*KERNEL_SIZE],
    output logic                       o_valid,
    output rwc_pkg::t_result           o_result
);
    import rwc_pkg::*;

    localparam int TAPS  = KERNEL_SIZE * KERNEL_SIZE;
    localparam int SUM_W = PROD_W + $clog2(TAPS + 1);

    logic [PROD_W-1:0] r_prod [3][TAPS];
    logic [SUM_W-1:0]  r_row  [3][KERNEL_SIZE];
    logic [SUM_W-1:0]  r_tot  [3];
    t_tag              r_tag_p, r_tag_r, r_tag_t;
    logic [SUM_W-1:0]  n_row  [3][KERNEL_SIZE];
    logic [SUM_W-1:0]  n_tot  [3];
    logic [CH_W-1:0]   clip   [3];

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            for (int t = 0; t < TAPS; t++) begin
                r_prod[c][t] <= PROD_W'(i_coef[t] * i_window[t][c*CH_W +: CH_W]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int kr = 0; kr < KERNEL_SIZE; kr++) begin
                n_row[c][kr] = '0;
                for (int kc = 0; kc < KERNEL_SIZE; kc++) begin
                    n_row[c][kr] = n_row[c][kr] + SUM_W'(r_prod[c][kr*KERNEL_SIZE+kc]);
                end
            end
            n_tot[c] = '0;
            for (int kr = 0; kr < KERNEL_SIZE; kr++) begin
                n_tot[c] = n_tot[c] + r_row[c][kr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_tot <= n_tot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_p <= '0;
            r_tag_r <= '0;
            r_tag_t <= '0;
        end else begin
            r_tag_p <= i_tag;
            r_tag_r <= r_tag_p;
            r_tag_t <= r_tag_r;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if ((r_tot[c] >> FRAC_W) > SUM_W'(255)) begin
                clip[c] = '1;
            end else begin
                clip[c] = r_tot[c][FRAC_W +: CH_W];
            end
        end
    end

    assign o_valid            = r_tag_t.valid;
    assign o_result.frame_end = r_tag_t.frame_end;
    assign o_result.red       = clip[0];
    assign o_result.green     = clip[1];
    assign o_result.blue      = clip[2];

endmodule

`default_nettype wire

FILE: sv/rgb_window_convolution.sv
// Streaming valid-mode RGB window convolution, top level.
// Pixels pass stage 0, stage 1, the MAC's product, row and total registers and
// the output queue. Throughput: one word per cycle while o_stall is low, loads
// and pixels alike; the line memory takes one read and one write per cycle. An
// 8-word output queue absorbs stalls. Reset clears counters and the queue and
// sets the sizes to 640 x 480; kernel and lines are undefined until written.
`default_nettype none

module rgb_window_convolution #(
    parameter int KERNEL_SIZE = rwc_pkg::KERNEL_SIZE_DEF,
    parameter int MAX_WIDTH   = rwc_pkg::MAX_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire                          i_command,
    input  wire [3:0]                    i_coef_row,
    input  wire [3:0]                    i_coef_col,
    input  wire [rwc_pkg::COEF_W-1:0]    i_coef_value,
    input  wire [rwc_pkg::CH_W-1:0]      i_red_in,
    input  wire [rwc_pkg::CH_W-1:0]      i_green_in,
    input  wire [rwc_pkg::CH_W-1:0]      i_blue_in,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [rwc_pkg::CH_W-1:0]     o_red_out,
    output logic [rwc_pkg::CH_W-1:0]     o_green_out,
    output logic [rwc_pkg::CH_W-1:0]     o_blue_out,
    output logic                         o_frame_end,
    input  wire                          i_cfg_we,
    input  wire [rwc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [rwc_pkg::CFG_W-1:0]     i_cfg_data
);
    import rwc_pkg::*;

    localparam int TAPS    = KERNEL_SIZE * KERNEL_SIZE;
    localparam int TAP_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int LINES   = (KERNEL_SIZE > 1) ? KERNEL_SIZE - 1 : 1;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int EW      = COL_W + 1;
    localparam int CMP_W   = ((EW > CFG_W) ? EW : CFG_W) + 1;
    localparam int DEPTH   = 8;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = PTR_W + 1;

    logic [CFG_W-1:0]  r_width, r_height;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [EW-1:0]     w_eff;
    logic [HGT_W-1:0]  h_eff;
    logic              accept, is_pix, produce, fend, col_last, row_last;

    logic [COEF_W-1:0] r_coef [TAPS];
    logic [PIX_W*LINES-1:0] r_rd, n_stack;
    logic [PIX_W-1:0]  r_win  [TAPS];
    logic [PIX_W-1:0]  col_vec [KERNEL_SIZE];

    logic              r_s0_valid, r_s0_prod, r_s0_fend;
    logic [COL_W-1:0]  r_s0_col;
    logic [PIX_W-1:0]  r_s0_pix;
    t_tag              r_s1_tag;

    logic              mac_valid;
    t_result           mac_result;
    t_result           r_fifo [DEPTH];
    logic [PTR_W-1:0]  r_wp, r_rp;
    logic [CNT_W-1:0]  r_cnt, r_pend;
    logic              take;

    always_comb begin
        if (r_width == '0) begin
            w_eff = EW'(1);
        end else if (CMP_W'(r_width) > CMP_W'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = HGT_W'(1);
        end else if (r_height > CFG_W'(MAX_HEIGHT)) begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end else begin
            h_eff = HGT_W'(r_height);
        end
    end

    assign accept   = i_valid && !o_stall;
    assign is_pix   = (i_command == CMD_PIXEL);
    assign col_last = (EW'(r_col) + EW'(1)) >= w_eff;
    assign row_last = (HGT_W'(r_row) + HGT_W'(1)) >= h_eff;
    assign produce  = ((EW'(r_col) + EW'(1)) >= EW'(KERNEL_SIZE))
                   && ((HGT_W'(r_row) + HGT_W'(1)) >= HGT_W'(KERNEL_SIZE))
                   && (EW'(r_col) < w_eff) && (HGT_W'(r_row) < h_eff);
    assign fend     = ((HGT_W'(r_row) + HGT_W'(1)) == h_eff)
                   && ((EW'(r_col) + EW'(1)) == w_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(640);
            r_height <= CFG_W'(480);
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (accept && is_pix) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // kernel load in stage 0 order so pixels ahead use the old kernel
    logic       r_s0_load;
    logic [3:0] r_s0_kr, r_s0_kc;
    logic [COEF_W-1:0] r_s0_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s0_load  <= 1'b0;
        end else begin
            r_s0_valid <= accept && is_pix;
            r_s0_load  <= accept && !is_pix;
        end
        r_s0_prod <= produce;
        r_s0_fend <= fend;
        r_s0_col  <= r_col;
        r_s0_pix  <= {i_blue_in, i_green_in, i_red_in};
        r_s0_kr   <= i_coef_row;
        r_s0_kc   <= i_coef_col;
        r_s0_coef <= i_coef_value;
    end

    always_ff @(posedge i_clk) begin
        if (r_s0_load && ({1'b0, r_s0_kr} < 5'(KERNEL_SIZE))
                && ({1'b0, r_s0_kc} < 5'(KERNEL_SIZE))) begin
            r_coef[TAP_W'(r_s0_kr * KERNEL_SIZE + r_s0_kc)] <= r_s0_coef;
        end
    end

    always_comb begin
        n_stack = '0;
        col_vec[KERNEL_SIZE-1] = r_s0_pix;
        if (KERNEL_SIZE > 1) begin
            n_stack[PIX_W-1:0] = r_s0_pix;
            for (int j = 1; j < LINES; j++) begin
                n_stack[j*PIX_W +: PIX_W] = r_rd[(j-1)*PIX_W +: PIX_W];
            end
            for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
                col_vec[KERNEL_SIZE-2-j] = r_rd[j*PIX_W +: PIX_W];
            end
        end
    end

    generate
        if (KERNEL_SIZE > 1) begin : g_lines
            logic [PIX_W*LINES-1:0] r_mem [MAX_WIDTH];
            always_ff @(posedge i_clk) begin
                if (accept && is_pix) begin
                    r_rd <= r_mem[r_col];
                end
                if (r_s0_valid) begin
                    r_mem[r_s0_col] <= n_stack;
                end
            end
        end else begin : g_nolines
            always_ff @(posedge i_clk) begin
                r_rd <= n_stack;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (r_s0_valid) begin
            for (int kr = 0; kr < KERNEL_SIZE; kr++) begin
                for (int kc = 0; kc < KERNEL_SIZE - 1; kc++) begin
                    r_win[kr*KERNEL_SIZE+kc] <= r_win[kr*KERNEL_SIZE+kc+1];
                end
                r_win[kr*KERNEL_SIZE+KERNEL_SIZE-1] <= col_vec[kr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
        end else begin
            r_s1_tag.valid     <= r_s0_valid && r_s0_prod;
            r_s1_tag.frame_end <= r_s0_fend;
        end
    end

    rwc_mac #(
        .KERNEL_SIZE (KERNEL_SIZE)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (r_s1_tag),
        .i_window (r_win),
        .i_coef   (r_coef),
        .o_valid  (mac_valid),
        .o_result (mac_result)
    );

    assign take    = o_valid && !i_stall;
    assign o_stall = (r_pend == CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_pend <= '0;
        end else begin
            if (mac_valid) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (take) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            r_cnt  <= r_cnt + CNT_W'(mac_valid) - CNT_W'(take);
            r_pend <= r_pend + CNT_W'(accept && is_pix && produce) - CNT_W'(take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mac_valid) begin
            r_fifo[r_wp] <= mac_result;
        end
    end

    assign o_valid     = (r_cnt != '0);
    assign o_red_out   = r_fifo[r_rp].red;
    assign o_green_out = r_fifo[r_rp].green;
    assign o_blue_out  = r_fifo[r_rp].blue;
    assign o_frame_end = r_fifo[r_rp].frame_end;

endmodule

`default_nettype wire

FILE: sv/rwc_checker.sv
// Port-level checks of the RGB window convolution, bound to its top level.
// Depends on rgb_window_convolution_defines.svh and rgb_window_convolution.
`default_nettype none
`include "rgb_window_convolution_defines.svh"

module rwc_port_checks (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       o_stall,
    input wire       o_valid,
    input wire       i_stall,
    input wire [7:0] o_red_out,
    input wire [7:0] o_green_out,
    input wire [7:0] o_blue_out,
    input wire       o_frame_end
);

    `RWC_ASSERT(a_hold_valid, i_clk, i_rst_n, o_valid && i_stall |=> o_valid)
    `RWC_ASSERT(a_hold_word, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_red_out) && $stable(o_green_out) && $stable(o_blue_out) && $stable(o_frame_end))
    `RWC_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_valid && !o_stall)
    `RWC_ASSERT(a_stall_after_accept, i_clk, i_rst_n, $rose(o_stall) |-> $past(i_valid && !o_stall))

endmodule

bind rgb_window_convolution rwc_port_checks u_rwc_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out),
    .o_frame_end (o_frame_end)
);

`default_nettype wire
